// ----- rtl/nsm_pkg.sv -----
// Shared types, field widths and defaults for the NFA symbol matcher.
package nsm_pkg;

  // Default sizing of the automaton
  localparam int MAX_STATES_DEF  = 16;
  localparam int MAX_SLOTS_DEF   = 4;
  localparam int SYMBOL_BITS_DEF = 8;

  // Fixed field widths of the transaction payload
  localparam int SRC_W  = 4;
  localparam int SLOT_W = 2;
  localparam int TGT_W  = 4;
  localparam int NUM_W  = 5;

  localparam logic [NUM_W-1:0] NUM_STATES_RESET = NUM_W'(16);

  // Operation codes of an input transaction
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SYMBOL = 1'b1
  } op_t;

  // Write command for one transition slot of a cell
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [TGT_W-1:0]  target;
    logic              used;
  } nsm_wr_t;

  // One result transaction
  typedef struct packed {
    logic alive;
    logic accepted;
    logic string_end;
  } nsm_result_t;

endpackage

// ----- rtl/nsm_cell.sv -----
// One state cell: holds the state's transition slots and adds its targets to the chain.
module nsm_cell #(
  parameter int MAX_STATES  = nsm_pkg::MAX_STATES_DEF,
  parameter int MAX_SLOTS   = nsm_pkg::MAX_SLOTS_DEF,
  parameter int SYMBOL_BITS = nsm_pkg::SYMBOL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  nsm_pkg::nsm_wr_t        wr,
  input  logic [SYMBOL_BITS-1:0]  symbol,
  input  logic                    fire,
  input  logic [MAX_STATES-1:0]   chain_in,
  output logic [MAX_STATES-1:0]   chain_out
);
  import nsm_pkg::*;

  logic [SYMBOL_BITS-1:0] slot_symbol [MAX_SLOTS];
  logic [TGT_W-1:0]       slot_target [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]   slot_used;
  logic [MAX_STATES-1:0]  slot_mask   [MAX_SLOTS];

  for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_slot
    // Slot index k is reachable only when the slot field can encode it
    localparam bit REACH = (k < (1 << SLOT_W));
    logic wr_hit;
    assign wr_hit = wr.en && REACH && (wr.slot == SLOT_W'(k));

    // Store the match symbol and target
    always_ff @(posedge clk) begin
      if (wr_hit) begin
        slot_symbol[k] <= symbol;
        slot_target[k] <= wr.target;
      end
    end

    // Hold the used flag; reset leaves every slot unused
    always_ff @(posedge clk) begin
      if (rst) begin
        slot_used[k] <= 1'b0;
      end else if (wr_hit) begin
        slot_used[k] <= wr.used;
      end
    end

    // Decode the target of a matching slot into a state mask
    always_comb begin
      for (int j = 0; j < MAX_STATES; j++) begin
        slot_mask[k][j] = fire && slot_used[k] && (slot_symbol[k] == symbol) &&
                          (j < (1 << TGT_W)) && (slot_target[k] == TGT_W'(j));
      end
    end
  end

  // Add this cell's targets to the mask handed to the next cell
  always_comb begin
    chain_out = chain_in;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      chain_out = chain_out | slot_mask[k];
    end
  end

endmodule

// ----- rtl/nsm_out_queue.sv -----
// Two-entry output register with skid stage for result transactions.
module nsm_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  nsm_pkg::nsm_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nsm_pkg::nsm_result_t out_data
);
  import nsm_pkg::*;

  logic        head_valid;
  nsm_result_t head;
  logic        skid_valid;
  nsm_result_t skid;
  logic        pop;

  assign pop       = head_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  // Advance the skid entry or the new result into the head; park a result when stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves with the valid flags
  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      head <= skid_valid ? skid : push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

// ----- rtl/nfa_symbol_matcher.sv -----
// Top level of the NFA symbol matcher: active state set, cell row and result queue.
// A symbol transaction's result passes through the registered output queue before it shows on the output.
// Throughput: one transaction per cycle while the result queue is not full; the next active set
//   comes from one pass through the OR chain of state cells, so each symbol finishes in the cycle it is accepted.
// Load transactions write one slot and give no result.
// Reset: all slots unused, only state 0 active, string matching, num_states 16, queue empty.
module nfa_symbol_matcher #(
  parameter int MAX_STATES  = nsm_pkg::MAX_STATES_DEF,
  parameter int MAX_SLOTS   = nsm_pkg::MAX_SLOTS_DEF,
  parameter int SYMBOL_BITS = nsm_pkg::SYMBOL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [nsm_pkg::NUM_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       op,
  input  logic [SYMBOL_BITS-1:0]     symbol,
  input  logic [nsm_pkg::SRC_W-1:0]  source_state,
  input  logic [nsm_pkg::SLOT_W-1:0] relation_slot,
  input  logic [nsm_pkg::TGT_W-1:0]  target_state,
  input  logic                       slot_used,
  input  logic                       first,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       alive,
  output logic                       accepted,
  output logic                       string_end
);
  import nsm_pkg::*;

  localparam int CNT_W = $clog2(MAX_STATES + 1);

  logic [NUM_W-1:0]      num_states;
  logic [CNT_W-1:0]      n_eff;
  logic [MAX_STATES-1:0] live;
  logic [MAX_STATES-1:0] accept_mask;
  logic [MAX_STATES-1:0] active_set;
  logic [MAX_STATES-1:0] active_set_next;
  logic                  still_matching;
  logic                  still_matching_next;
  logic [MAX_STATES-1:0] cur_set;
  logic                  cur_matching;
  logic [MAX_STATES-1:0] chain [MAX_STATES+1];
  logic [MAX_STATES-1:0] next_set;
  logic                  in_fire;
  logic                  is_load;
  logic                  is_symbol;
  logic                  queue_full;
  nsm_result_t           result;
  nsm_result_t           out_data;

  assign in_fire   = in_valid && !in_stall;
  assign is_load   = in_fire && (op_t'(op) == OP_LOAD);
  assign is_symbol = in_fire && (op_t'(op) == OP_SYMBOL);
  assign in_stall  = queue_full;
  assign cfg_ready = 1'b1;

  // Hold the state count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= NUM_STATES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_states <= cfg_data;
    end
  end

  // Clamp the state count and decode the live and accepting states
  always_comb begin
    if (num_states == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(num_states) > MAX_STATES) begin
      n_eff = CNT_W'(MAX_STATES);
    end else begin
      n_eff = CNT_W'(num_states);
    end
    for (int i = 0; i < MAX_STATES; i++) begin
      live[i]        = (i < int'(n_eff));
      accept_mask[i] = (i == int'(n_eff) - 1);
    end
  end

  // Restart from state 0 on a first symbol
  assign cur_set      = first ? MAX_STATES'(1) : active_set;
  assign cur_matching = first || still_matching;

  // Row of state cells, each adding its targets to the chain
  assign chain[0] = '0;
  for (genvar i = 0; i < MAX_STATES; i++) begin : g_cell
    localparam bit REACH = (i < (1 << SRC_W));
    nsm_wr_t wr;
    assign wr.en     = is_load && REACH && (source_state == SRC_W'(i)) &&
                       (int'(relation_slot) < MAX_SLOTS);
    assign wr.slot   = relation_slot;
    assign wr.target = target_state;
    assign wr.used   = slot_used;

    nsm_cell #(
      .MAX_STATES  (MAX_STATES),
      .MAX_SLOTS   (MAX_SLOTS),
      .SYMBOL_BITS (SYMBOL_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr        (wr),
      .symbol    (symbol),
      .fire      (cur_set[i] && live[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  assign next_set = chain[MAX_STATES] & live;

  // Advance the active set and build the result
  always_comb begin
    active_set_next     = active_set;
    still_matching_next = still_matching;
    result.alive        = 1'b0;
    result.accepted     = 1'b0;
    result.string_end   = last;
    if (is_symbol) begin
      if (cur_matching) begin
        active_set_next     = next_set;
        still_matching_next = |next_set;
        result.alive        = |next_set;
        result.accepted     = last && (|(next_set & accept_mask));
      end else begin
        active_set_next     = cur_set;
        still_matching_next = 1'b0;
      end
    end
  end

  // Hold the active set and the match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active_set     <= MAX_STATES'(1);
      still_matching <= 1'b1;
    end else begin
      active_set     <= active_set_next;
      still_matching <= still_matching_next;
    end
  end

  nsm_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (is_symbol),
    .push_data (result),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign alive      = out_data.alive;
  assign accepted   = out_data.accepted;
  assign string_end = out_data.string_end;

  // The match flag tracks whether any state is active
  a_match_flag: assert property (@(posedge clk) disable iff (rst)
    still_matching == (active_set != '0))
    else $error("match flag disagrees with active set");

  // A verdict of acceptance comes only on a live final symbol
  a_accept_live: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (alive && string_end))
    else $error("accepted without alive string end");

  // The input stalls only while a result is waiting
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // A load transaction leaves the active set alone
  a_load_stable: assert property (@(posedge clk) disable iff (rst)
    is_load |=> $stable(active_set))
    else $error("load changed the active set");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the NFA symbol matcher: directed table, then random automata.
module testbench;
  import nsm_pkg::*;

  localparam int N_ST        = MAX_STATES_DEF;
  localparam int N_SL        = MAX_SLOTS_DEF;
  localparam int SYM_W       = SYMBOL_BITS_DEF;
  localparam int HOLD_CYCLES = 120;
  localparam int PLAN_LEN    = 12;
  localparam int HOLD_AT     = 9;
  localparam int DIR_ROWS    = 17;

  typedef struct packed {
    op_t               op;
    logic [SYM_W-1:0]  sym;
    logic [SRC_W-1:0]  src;
    logic [SLOT_W-1:0] rslot;
    logic [TGT_W-1:0]  tgt;
    logic              used;
    logic              first;
    logic              last;
  } nfa_item_t;

  localparam int ITEM_W = $bits(nfa_item_t);

  typedef struct packed {
    nfa_item_t   item;
    logic        typed;
    nsm_result_t want;
  } dir_row_t;

  logic              clk;
  logic              rst          = 1'b1;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [NUM_W-1:0]  cfg_data     = NUM_STATES_RESET;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic              op           = OP_SYMBOL;
  logic [SYM_W-1:0]  symbol       = '0;
  logic [SRC_W-1:0]  source_state = '0;
  logic [SLOT_W-1:0] relation_slot = '0;
  logic [TGT_W-1:0]  target_state = '0;
  logic              slot_used    = 1'b0;
  logic              first        = 1'b0;
  logic              last         = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic              alive;
  logic              accepted;
  logic              string_end;

  nfa_symbol_matcher dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .symbol        (symbol),
    .source_state  (source_state),
    .relation_slot (relation_slot),
    .target_state  (target_state),
    .slot_used     (slot_used),
    .first         (first),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .alive         (alive),
    .accepted      (accepted),
    .string_end    (string_end)
  );

  // Predictor copy of the transition store, active set and register
  bit [SYM_W-1:0] tr_sym  [N_ST][N_SL];
  bit [TGT_W-1:0] tr_tgt  [N_ST][N_SL];
  bit             tr_used [N_ST][N_SL];
  bit [N_ST-1:0]  act_states = N_ST'(1);
  bit             matching   = 1'b1;
  bit [NUM_W-1:0] cfg_states = NUM_STATES_RESET;

  nsm_result_t    verdict_q [$];
  int             mismatches = 0;
  int             sent_items = 0;

  // Idling controls shared by the sender and the receiver
  bit             calm       = 1'b0;
  int             gap_pct    = 0;
  int             stall_pct  = 0;
  bit             hold_req   = 1'b0;
  bit             hold_done  = 1'b0;
  int             pct_levels [3] = '{0, 10, 35};
  bit [SYM_W-1:0] alphabet [4];

  bit [NUM_W-1:0] state_plan [PLAN_LEN] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd31, 5'd17,
                                            5'd7, 5'd3, 5'd12, 5'd16, 5'd5, 5'd16};

  // Directed transactions: op, symbol, source, slot, target, used, first, last;
  // then whether the verdict is typed in, and the verdict alive/accepted/end
  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty store right after reset: the set dies at once
    '{'{OP_SYMBOL, 8'h00, 4'd0, 2'd0, 4'd0, 1'b0, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1}},
    // rejected string ignores further symbols
    '{'{OP_SYMBOL, 8'hFF, 4'd15, 2'd3, 4'd15, 1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 8'h61, 4'd0, 2'd0, 4'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD, 8'hFF, 4'd1, 2'd3, 4'd15, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD, 8'h80, 4'd15, 2'd3, 4'd15, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_LOAD, 8'h00, 4'd0, 2'd1, 4'd0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    // loaded then left unused
    '{'{OP_LOAD, 8'h61, 4'd1, 2'd1, 4'd2, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD, 8'h61, 4'd0, 2'd2, 4'd15, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SYMBOL, 8'h61, 4'd0, 2'd0, 4'd0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_SYMBOL, 8'hFF, 4'd0, 2'd0, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    // symbol after last with no first carries the set on
    '{'{OP_SYMBOL, 8'h80, 4'd0, 2'd0, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_SYMBOL, 8'h00, 4'd0, 2'd0, 4'd0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_SYMBOL, 8'h61, 4'd0, 2'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SYMBOL, 8'h61, 4'd0, 2'd0, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_SYMBOL, 8'h80, 4'd0, 2'd0, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1}},
    '{'{OP_SYMBOL, 8'h00, 4'd0, 2'd0, 4'd0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_SYMBOL, 8'h00, 4'd0, 2'd0, 4'd0, 1'b0, 1'b1, 1'b1}, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the predicted automaton by one transaction; return 1 if it yields a verdict
  function automatic bit step_automaton(input nfa_item_t it, output nsm_result_t res);
    bit [N_ST-1:0] nxt;
    int            n;
    n   = (cfg_states == 0) ? 1 : ((cfg_states > N_ST) ? N_ST : int'(cfg_states));
    res = '0;
    if (it.op == OP_LOAD) begin
      tr_sym[it.src][it.rslot]  = it.sym;
      tr_tgt[it.src][it.rslot]  = it.tgt;
      tr_used[it.src][it.rslot] = it.used;
      return 1'b0;
    end
    if (it.first) begin
      act_states = N_ST'(1);
      matching   = 1'b1;
    end
    if (matching) begin
      nxt = '0;
      for (int s = 0; s < n; s++) begin
        if (act_states[s]) begin
          for (int k = 0; k < N_SL; k++) begin
            if (tr_used[s][k] && tr_sym[s][k] == it.sym && tr_tgt[s][k] < n)
              nxt[tr_tgt[s][k]] = 1'b1;
          end
        end
      end
      act_states = nxt;
      if (act_states == '0) matching = 1'b0;
    end
    res.alive      = matching;
    res.accepted   = it.last && matching && act_states[n-1];
    res.string_end = it.last;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic got, input logic want);
    $display("mismatch on %s at %0t: got %b, expected %b", what, $time, got, want);
    mismatches++;
  endtask

  // Offer one transaction, hold it until accepted, then predict its verdict
  task automatic push_item(input nfa_item_t it, input bit typed, input nsm_result_t want);
    nsm_result_t res;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= it.op;
    symbol        <= it.sym;
    source_state  <= it.src;
    relation_slot <= it.rslot;
    target_state  <= it.tgt;
    slot_used     <= it.used;
    first         <= it.first;
    last          <= it.last;
    do @(posedge clk); while (in_stall);
    sent_items++;
    if (step_automaton(it, res)) verdict_q.push_back(typed ? want : res);
  endtask

  // Stop offering and wait until every verdict has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_state_count(input bit [NUM_W-1:0] setting);
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cfg_states  = setting;
  endtask

  function automatic nfa_item_t random_load(input int n_eff);
    nfa_item_t it;
    it    = nfa_item_t'(ITEM_W'($urandom));
    it.op = OP_LOAD;
    if ($urandom_range(0, 4) != 0) it.src = SRC_W'($urandom_range(0, n_eff - 1));
    if ($urandom_range(0, 4) != 0) it.tgt = TGT_W'($urandom_range(0, n_eff - 1));
    if ($urandom_range(0, 4) != 0) it.sym = alphabet[$urandom_range(0, 3)];
    it.used = ($urandom_range(0, 9) != 0);
    return it;
  endfunction

  // One string mostly over the phase alphabet, now and then with a missing first or last flag
  task automatic feed_string();
    nfa_item_t it;
    int        len;
    len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      it    = nfa_item_t'(ITEM_W'($urandom));
      it.op = OP_SYMBOL;
      if ($urandom_range(0, 99) < 85) it.sym = alphabet[$urandom_range(0, 3)];
      it.first = (k == 0) ? ($urandom_range(0, 99) >= 8) : ($urandom_range(0, 99) < 3);
      it.last  = (k == len - 1) ? ($urandom_range(0, 99) >= 8) : ($urandom_range(0, 99) < 3);
      push_item(it, 1'b0, '0);
    end
  endtask

  // Reconfigure while idle, build an automaton, then run strings mixed with noise
  task automatic run_phase(input bit [NUM_W-1:0] setting, input int budget, input bit hold);
    int n_eff;
    int stop_at;
    int r;
    drain_results();
    write_state_count(setting);
    n_eff = (setting == 0) ? 1 : ((setting > N_ST) ? N_ST : int'(setting));
    for (int k = 0; k < 4; k++) alphabet[k] = SYM_W'($urandom);
    gap_pct   = hold ? 0 : pct_levels[$urandom_range(0, 2)];
    stall_pct = pct_levels[$urandom_range(0, 2)];
    hold_req  = hold;
    for (int k = $urandom_range(6, 24); k > 0; k--) push_item(random_load(n_eff), 1'b0, '0);
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        push_item(nfa_item_t'(ITEM_W'($urandom)), 1'b0, '0);
      else if (r < 12)
        push_item(random_load(n_eff), 1'b0, '0);
      else
        feed_string();
    end
  endtask

  // Receiver: random stall bursts, and one long hold-off when asked
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done  = 1'b1;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result transaction with the oldest predicted verdict
  always @(posedge clk) begin : verdict_check
    nsm_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch("unexpected result", 1'b1, 1'b0);
      end else begin
        want = verdict_q.pop_front();
        if (alive !== want.alive) flag_mismatch("alive", alive, want.alive);
        if (accepted !== want.accepted) flag_mismatch("accepted", accepted, want.accepted);
        if (string_end !== want.string_end)
          flag_mismatch("string_end", string_end, want.string_end);
      end
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Walk the directed table with the reset configuration
    for (int i = 0; i < DIR_ROWS; i++)
      push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    // Random phases; the long hold-off sits before the last, calm phases
    for (int i = 0; i < PLAN_LEN; i++) begin
      calm = (i >= PLAN_LEN - 2);
      if (i == HOLD_AT) run_phase(5'd16, 150, 1'b1);
      run_phase(state_plan[i], 100, 1'b0);
    end
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
